// ===== hw/rtl/tun_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_pkg
// Widths, constants and cell types shared by the triangle unit normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int IN_W        = 32;
   localparam int OUT_W       = 18;

   localparam int EDGE_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int SQ_W    = 2 * CROSS_W;
   localparam int LEN_W   = SQ_W + 2;
   localparam int ACC_W   = LEN_W + 2 * FRAC_BITS + 6;
   localparam int Q_W     = FRAC_BITS + 1;
   localparam int K_W     = $clog2(Q_W);
   localparam int NCELL   = Q_W;
   localparam int MUL_LO  = (CROSS_W + 1) / 2;
   localparam int MUL_HI  = CROSS_W - MUL_LO;
   localparam int NEG_W   = (Q_W + 1 > OUT_W) ? Q_W + 1 : OUT_W;

   typedef struct packed {
      logic signed [ACC_W-1:0] r;
      logic signed [ACC_W-1:0] p;
      logic        [Q_W-1:0]   q;
      logic                    neg;
   } lane_type;

   typedef struct packed {
      lane_type [2:0]     lane;
      logic [LEN_W-1:0]   len2;
      logic               degen;
   } cell_type;

endpackage
`default_nettype wire

// ===== hw/rtl/triangle_unit_normal_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// Unit face normal of a triangle, signed fixed point, rounded to nearest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the nine vertex coordinates on req_* and raise
//   start; a transfer happens at every rising edge with start high and busy
//   low. busy is always low, so a new triangle may be given every cycle.
//   Result channel: rsp_strobe is high for exactly one cycle with nx, ny, nz
//   and degenerate on rsp_*; the receiver takes it in that cycle.
//   Throughput: one triangle per cycle. The edge and cross product stages,
//   a two-stage split multiplier for the squares, the length sum, and a
//   chain of FRAC_BITS+1 search cells (one quotient bit per cell, three
//   components side by side) make up the pipeline.
//   A zero cross product gives the zero vector with degenerate set.
//   Reset clears all valid flags; items in flight are dropped and no result
//   is shown until new transfers come through.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [tun_pkg::IN_W-1:0]    req_ax,
   input  wire logic [tun_pkg::IN_W-1:0]    req_ay,
   input  wire logic [tun_pkg::IN_W-1:0]    req_az,
   input  wire logic [tun_pkg::IN_W-1:0]    req_bx,
   input  wire logic [tun_pkg::IN_W-1:0]    req_by_coord,
   input  wire logic [tun_pkg::IN_W-1:0]    req_bz,
   input  wire logic [tun_pkg::IN_W-1:0]    req_cx,
   input  wire logic [tun_pkg::IN_W-1:0]    req_cy,
   input  wire logic [tun_pkg::IN_W-1:0]    req_cz,
   output logic                             rsp_strobe,
   output logic signed [tun_pkg::OUT_W-1:0] rsp_nx,
   output logic signed [tun_pkg::OUT_W-1:0] rsp_ny,
   output logic signed [tun_pkg::OUT_W-1:0] rsp_nz,
   output logic                             rsp_degenerate
);
   import tun_pkg::*;

   logic signed [COORD_WIDTH-1:0] vc [3];
   logic signed [COORD_WIDTH-1:0] vxa [3];
   logic signed [COORD_WIDTH-1:0] vxb [3];

   logic                       v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic signed [EDGE_W-1:0]   e_ff [3];
   logic signed [EDGE_W-1:0]   f_ff [3];
   logic signed [PROD_W-1:0]   pa_ff [3];
   logic signed [PROD_W-1:0]   pb_ff [3];
   logic signed [CROSS_W-1:0]  cr_ff [3];
   logic        [CROSS_W-1:0]  mag_ff [3];
   logic        [2:0]          neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic        [SQ_W-1:0]     sq [3];
   logic        [SQ_W-1:0]     sq7_ff [3];
   logic        [LEN_W-1:0]    len7_ff;
   cell_type                   init_in, init_ff;

   logic                       cv [NCELL+1];
   cell_type                   cd [NCELL+1];

   logic                       strobe_ff;
   logic signed [OUT_W-1:0]    n_ff [3];
   logic signed [OUT_W-1:0]    n_in [3];
   logic                       degen_ff;
   logic signed [NEG_W-1:0]    qs [3];

   assign busy = 1'b0;

   // hold each vertex as signed coordinates
   always_comb begin
      vxa[0] = signed'(req_ax[COORD_WIDTH-1:0]);
      vxa[1] = signed'(req_ay[COORD_WIDTH-1:0]);
      vxa[2] = signed'(req_az[COORD_WIDTH-1:0]);
      vxb[0] = signed'(req_bx[COORD_WIDTH-1:0]);
      vxb[1] = signed'(req_by_coord[COORD_WIDTH-1:0]);
      vxb[2] = signed'(req_bz[COORD_WIDTH-1:0]);
      vc[0]  = signed'(req_cx[COORD_WIDTH-1:0]);
      vc[1]  = signed'(req_cy[COORD_WIDTH-1:0]);
      vc[2]  = signed'(req_cz[COORD_WIDTH-1:0]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e_ff[i] <= EDGE_W'(vxa[i]) - EDGE_W'(vxb[i]);
         f_ff[i] <= EDGE_W'(vxb[i]) - EDGE_W'(vc[i]);
      end
      pa_ff[0] <= e_ff[1] * f_ff[2];
      pb_ff[0] <= e_ff[2] * f_ff[1];
      pa_ff[1] <= e_ff[2] * f_ff[0];
      pb_ff[1] <= e_ff[0] * f_ff[2];
      pa_ff[2] <= e_ff[0] * f_ff[1];
      pb_ff[2] <= e_ff[1] * f_ff[0];
      for (int i = 0; i < 3; i++) begin
         cr_ff[i]   <= CROSS_W'(pa_ff[i]) - CROSS_W'(pb_ff[i]);
         neg4_ff[i] <= cr_ff[i][CROSS_W-1];
         mag_ff[i]  <= cr_ff[i][CROSS_W-1] ? CROSS_W'(-cr_ff[i]) : CROSS_W'(cr_ff[i]);
         sq7_ff[i]  <= sq[i];
      end
      neg5_ff <= neg4_ff;
      neg6_ff <= neg5_ff;
      neg7_ff <= neg6_ff;
      len7_ff <= LEN_W'(sq[0]) + LEN_W'(sq[1]) + LEN_W'(sq[2]);
      init_ff <= init_in;
   end

   for (genvar g = 0; g < 3; g++) begin : g_sq
      tun_mul u_mul (
         .clock (clock),
         .a     (mag_ff[g]),
         .b     (mag_ff[g]),
         .prod  (sq[g])
      );
   end

   always_comb begin
      init_in.len2  = len7_ff;
      init_in.degen = (len7_ff == '0);
      for (int i = 0; i < 3; i++) begin
         init_in.lane[i].r   = (signed'(ACC_W'(sq7_ff[i])) <<< (2 * FRAC_BITS + 2))
                             - signed'(ACC_W'(len7_ff));
         init_in.lane[i].p   = -signed'(ACC_W'(len7_ff));
         init_in.lane[i].q   = '0;
         init_in.lane[i].neg = neg7_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   assign cv[0] = v8_ff;
   assign cd[0] = init_ff;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      tun_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bit_idx   (K_W'(NCELL - 1 - g)),
         .in_valid  (cv[g]),
         .in_data   (cd[g]),
         .out_valid (cv[g+1]),
         .out_data  (cd[g+1])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qs[i]   = signed'(NEG_W'(cd[NCELL].lane[i].q));
         n_in[i] = cd[NCELL].lane[i].neg ? OUT_W'(-qs[i]) : OUT_W'(qs[i]);
         if (cd[NCELL].degen) begin
            n_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cv[NCELL];
      end
      for (int i = 0; i < 3; i++) begin
         n_ff[i] <= n_in[i];
      end
      degen_ff <= cd[NCELL].degen;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_nx         = n_ff[0];
   assign rsp_ny         = n_ff[1];
   assign rsp_nz         = n_ff[2];
   assign rsp_degenerate = degen_ff;

`ifndef SYNTHESIS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |-> rsp_nx == '0 && rsp_ny == '0 && rsp_nz == '0)
      else $error("degenerate result with nonzero normal");

   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      cv[NCELL] && !cd[NCELL].degen |->
         cd[NCELL].lane[0].q <= Q_W'(1 << FRAC_BITS) &&
         cd[NCELL].lane[1].q <= Q_W'(1 << FRAC_BITS) &&
         cd[NCELL].lane[2].q <= Q_W'(1 << FRAC_BITS))
      else $error("normal component beyond unit length");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(cv[NCELL]))
      else $error("result strobe without a finished cell chain item");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/tun_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_mul
// Two-stage unsigned multiplier built from four registered partial products.
// ----------------------------------------------------------------------------
module tun_mul (
   input  wire logic                        clock,
   input  wire logic [tun_pkg::CROSS_W-1:0] a,
   input  wire logic [tun_pkg::CROSS_W-1:0] b,
   output logic      [tun_pkg::SQ_W-1:0]    prod
);
   import tun_pkg::*;

   logic [2*MUL_LO-1:0]      pp_ll_ff, pp_ll_in;
   logic [MUL_LO+MUL_HI-1:0] pp_lh_ff, pp_lh_in;
   logic [MUL_LO+MUL_HI-1:0] pp_hl_ff, pp_hl_in;
   logic [2*MUL_HI-1:0]      pp_hh_ff, pp_hh_in;
   logic [SQ_W-1:0]          prod_ff, prod_in;

   always_comb begin
      pp_ll_in = a[MUL_LO-1:0] * b[MUL_LO-1:0];
      pp_lh_in = a[MUL_LO-1:0] * b[CROSS_W-1:MUL_LO];
      pp_hl_in = a[CROSS_W-1:MUL_LO] * b[MUL_LO-1:0];
      pp_hh_in = a[CROSS_W-1:MUL_LO] * b[CROSS_W-1:MUL_LO];
      prod_in  = (SQ_W'(pp_hh_ff) << (2 * MUL_LO))
               + (SQ_W'(pp_lh_ff) << MUL_LO)
               + (SQ_W'(pp_hl_ff) << MUL_LO)
               + SQ_W'(pp_ll_ff);
   end

   always_ff @(posedge clock) begin
      pp_ll_ff <= pp_ll_in;
      pp_lh_ff <= pp_lh_in;
      pp_hl_ff <= pp_hl_in;
      pp_hh_ff <= pp_hh_in;
      prod_ff  <= prod_in;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/tun_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_cell
// One digit of the rounded quotient search for three lanes.
// ----------------------------------------------------------------------------
module tun_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [tun_pkg::K_W-1:0] bit_idx,
   input  wire logic                    in_valid,
   input  wire tun_pkg::cell_type       in_data,
   output logic                         out_valid,
   output tun_pkg::cell_type            out_data
);
   import tun_pkg::*;

   logic                    valid_ff;
   cell_type                data_ff, data_in;
   logic signed [ACC_W-1:0] len_x;
   logic signed [ACC_W-1:0] trial [3];

   always_comb begin
      data_in = in_data;
      len_x   = signed'(ACC_W'(in_data.len2));
      for (int i = 0; i < 3; i++) begin
         trial[i] = in_data.lane[i].r - (in_data.lane[i].p <<< (bit_idx + 2))
                  - (len_x <<< (2 * bit_idx + 2));
         if (!trial[i][ACC_W-1]) begin
            data_in.lane[i].r          = trial[i];
            data_in.lane[i].p          = in_data.lane[i].p + (len_x <<< (bit_idx + 1));
            data_in.lane[i].q[bit_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire
